// ===== sv/cabac_pkg.sv =====
// Package: shared types, mode codes and probability tables of the arithmetic decoder.
package cabac_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    MODE_DECISION  = 2'd0,
    MODE_BYPASS    = 2'd1,
    MODE_TERMINATE = 2'd2,
    MODE_START     = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e      mode;
    logic [5:0] state;
    logic       mps;
    logic [8:0] window;
  } item_t;

  localparam logic [8:0] StartRange = 9'd510;
  localparam logic [8:0] TermDec    = 9'd2;

  function automatic logic [7:0] lps_range(input logic [5:0] s, input logic [1:0] q);
    logic [31:0] row;
    begin
      case (s)
        6'd0:  row = {8'd240, 8'd208, 8'd176, 8'd128};
        6'd1:  row = {8'd227, 8'd197, 8'd167, 8'd128};
        6'd2:  row = {8'd216, 8'd187, 8'd158, 8'd128};
        6'd3:  row = {8'd205, 8'd178, 8'd150, 8'd123};
        6'd4:  row = {8'd195, 8'd169, 8'd142, 8'd116};
        6'd5:  row = {8'd185, 8'd160, 8'd135, 8'd111};
        6'd6:  row = {8'd175, 8'd152, 8'd128, 8'd105};
        6'd7:  row = {8'd166, 8'd144, 8'd122, 8'd100};
        6'd8:  row = {8'd158, 8'd137, 8'd116, 8'd95};
        6'd9:  row = {8'd150, 8'd130, 8'd110, 8'd90};
        6'd10: row = {8'd142, 8'd123, 8'd104, 8'd85};
        6'd11: row = {8'd135, 8'd117, 8'd99, 8'd81};
        6'd12: row = {8'd128, 8'd111, 8'd94, 8'd77};
        6'd13: row = {8'd122, 8'd105, 8'd89, 8'd73};
        6'd14: row = {8'd116, 8'd100, 8'd85, 8'd69};
        6'd15: row = {8'd110, 8'd95, 8'd80, 8'd66};
        6'd16: row = {8'd104, 8'd90, 8'd76, 8'd62};
        6'd17: row = {8'd99, 8'd86, 8'd72, 8'd59};
        6'd18: row = {8'd94, 8'd81, 8'd69, 8'd56};
        6'd19: row = {8'd89, 8'd77, 8'd65, 8'd53};
        6'd20: row = {8'd85, 8'd73, 8'd62, 8'd51};
        6'd21: row = {8'd80, 8'd69, 8'd59, 8'd48};
        6'd22: row = {8'd76, 8'd66, 8'd56, 8'd46};
        6'd23: row = {8'd72, 8'd63, 8'd53, 8'd43};
        6'd24: row = {8'd69, 8'd59, 8'd50, 8'd41};
        6'd25: row = {8'd65, 8'd56, 8'd48, 8'd39};
        6'd26: row = {8'd62, 8'd54, 8'd45, 8'd37};
        6'd27: row = {8'd59, 8'd51, 8'd43, 8'd35};
        6'd28: row = {8'd56, 8'd48, 8'd41, 8'd33};
        6'd29: row = {8'd53, 8'd46, 8'd39, 8'd32};
        6'd30: row = {8'd50, 8'd43, 8'd37, 8'd30};
        6'd31: row = {8'd48, 8'd41, 8'd35, 8'd29};
        6'd32: row = {8'd45, 8'd39, 8'd33, 8'd27};
        6'd33: row = {8'd43, 8'd37, 8'd31, 8'd26};
        6'd34: row = {8'd41, 8'd35, 8'd30, 8'd24};
        6'd35: row = {8'd39, 8'd33, 8'd28, 8'd23};
        6'd36: row = {8'd37, 8'd32, 8'd27, 8'd22};
        6'd37: row = {8'd35, 8'd30, 8'd26, 8'd21};
        6'd38: row = {8'd33, 8'd29, 8'd24, 8'd20};
        6'd39: row = {8'd31, 8'd27, 8'd23, 8'd19};
        6'd40: row = {8'd30, 8'd26, 8'd22, 8'd18};
        6'd41: row = {8'd28, 8'd25, 8'd21, 8'd17};
        6'd42: row = {8'd27, 8'd23, 8'd20, 8'd16};
        6'd43: row = {8'd25, 8'd22, 8'd19, 8'd15};
        6'd44: row = {8'd24, 8'd21, 8'd18, 8'd14};
        6'd45: row = {8'd23, 8'd20, 8'd17, 8'd14};
        6'd46: row = {8'd22, 8'd19, 8'd16, 8'd13};
        6'd47: row = {8'd21, 8'd18, 8'd15, 8'd12};
        6'd48: row = {8'd20, 8'd17, 8'd14, 8'd12};
        6'd49: row = {8'd19, 8'd16, 8'd14, 8'd11};
        6'd50: row = {8'd18, 8'd15, 8'd13, 8'd11};
        6'd51: row = {8'd17, 8'd15, 8'd12, 8'd10};
        6'd52: row = {8'd16, 8'd14, 8'd12, 8'd10};
        6'd53: row = {8'd15, 8'd13, 8'd11, 8'd9};
        6'd54: row = {8'd14, 8'd12, 8'd11, 8'd9};
        6'd55: row = {8'd14, 8'd12, 8'd10, 8'd8};
        6'd56: row = {8'd13, 8'd11, 8'd9, 8'd8};
        6'd57: row = {8'd12, 8'd11, 8'd9, 8'd7};
        6'd58: row = {8'd12, 8'd10, 8'd9, 8'd7};
        6'd59: row = {8'd11, 8'd10, 8'd8, 8'd7};
        6'd60: row = {8'd11, 8'd9, 8'd8, 8'd6};
        6'd61: row = {8'd10, 8'd9, 8'd7, 8'd6};
        6'd62: row = {8'd9, 8'd8, 8'd7, 8'd6};
        default: row = {8'd2, 8'd2, 8'd2, 8'd2};
      endcase
      lps_range = row[8*q +: 8];
    end
  endfunction

  function automatic logic [5:0] lps_next(input logic [5:0] s);
    logic [5:0] r;
    begin
      case (s)
        6'd0, 6'd1:                 r = 6'd0;
        6'd2:                       r = 6'd1;
        6'd3, 6'd4:                 r = 6'd2;
        6'd5, 6'd6:                 r = 6'd4;
        6'd7:                       r = 6'd5;
        6'd8:                       r = 6'd6;
        6'd9:                       r = 6'd7;
        6'd10:                      r = 6'd8;
        6'd11, 6'd12:               r = 6'd9;
        6'd13, 6'd14:               r = 6'd11;
        6'd15:                      r = 6'd12;
        6'd16, 6'd17:               r = 6'd13;
        6'd18, 6'd19:               r = 6'd15;
        6'd20, 6'd21:               r = 6'd16;
        6'd22, 6'd23:               r = 6'd18;
        6'd24, 6'd25:               r = 6'd19;
        6'd26, 6'd27:               r = 6'd21;
        6'd28, 6'd29:               r = 6'd22;
        6'd30:                      r = 6'd23;
        6'd31, 6'd32:               r = 6'd24;
        6'd33:                      r = 6'd25;
        6'd34, 6'd35:               r = 6'd26;
        6'd36, 6'd37:               r = 6'd27;
        6'd38:                      r = 6'd28;
        6'd39, 6'd40:               r = 6'd29;
        6'd41, 6'd42, 6'd43:        r = 6'd30;
        6'd44:                      r = 6'd31;
        6'd45, 6'd46:               r = 6'd32;
        6'd47, 6'd48, 6'd49:        r = 6'd33;
        6'd50, 6'd51:               r = 6'd34;
        6'd52, 6'd53, 6'd54:        r = 6'd35;
        6'd55, 6'd56, 6'd57:        r = 6'd36;
        6'd58, 6'd59, 6'd60:        r = 6'd37;
        6'd61, 6'd62:               r = 6'd38;
        default:                    r = 6'd63;
      endcase
      lps_next = r;
    end
  endfunction

endpackage

// ===== sv/cabac_front.sv =====
// Front end: takes input words, splits the context and queues the items.
module cabac_front
  import cabac_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [6:0] ctx_state_i,
  input  logic [8:0] stream_bits_i,
  output logic       q_valid_o,
  input  logic       q_pop_i,
  output item_t      q_item_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t              mem_q [Depth];
  logic [PtrW-1:0]    wr_q, rd_q;
  logic [PtrW:0]      cnt_q;
  logic               push, pop;
  item_t              item;

  assign in_stall_o = (cnt_q == (PtrW+1)'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    item.mode   = mode_e'(mode_i);
    item.state  = ctx_state_i[6:1];
    item.mps    = ctx_state_i[0];
    item.window = stream_bits_i;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

// ===== sv/cabac_back.sv =====
// Back end: range and offset registers, bin decode, renormalization and output register.
module cabac_back
  import cabac_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  output logic       q_pop_o,
  input  item_t      q_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       bin_o,
  output logic [6:0] new_ctx_state_o,
  output logic [3:0] bits_used_o
);
  logic [8:0] range_q, range_d, offset_q, offset_d;
  logic       valid_q;
  logic       bin_q, bin_d;
  logic [6:0] ctx_q, ctx_d;
  logic [3:0] used_q, used_d;
  logic       fire;

  logic [8:0] rlps, rmps, r_pre, o_pre;
  logic [9:0] byp;
  logic       do_renorm;
  logic [3:0] shift;
  logic [5:0] s_new;
  logic       mps_new;

  assign fire    = q_valid_i && (!valid_q || !out_stall_i);
  assign q_pop_o = fire;

  always_comb begin
    rlps      = {1'b0, lps_range(q_item_i.state, range_q[7:6])};
    rmps      = range_q - rlps;
    r_pre     = range_q;
    o_pre     = offset_q;
    bin_d     = 1'b0;
    ctx_d     = {q_item_i.state, q_item_i.mps};
    do_renorm = 1'b0;
    byp       = {offset_q, q_item_i.window[8]};
    s_new     = q_item_i.state;
    mps_new   = q_item_i.mps;
    used_d    = 4'd0;
    case (q_item_i.mode)
      MODE_DECISION: begin
        do_renorm = 1'b1;
        if (offset_q >= rmps) begin
          bin_d = ~q_item_i.mps;
          o_pre = offset_q - rmps;
          r_pre = rlps;
          if (q_item_i.state == 6'd0) begin
            mps_new = ~q_item_i.mps;
          end
          s_new = lps_next(q_item_i.state);
        end else begin
          bin_d = q_item_i.mps;
          r_pre = rmps;
          s_new = (q_item_i.state >= 6'd62) ? q_item_i.state : q_item_i.state + 6'd1;
        end
        ctx_d = {s_new, mps_new};
      end
      MODE_BYPASS: begin
        used_d = 4'd1;
        if (byp >= {1'b0, range_q}) begin
          byp   = byp - {1'b0, range_q};
          bin_d = 1'b1;
        end
        o_pre = byp[8:0];
      end
      MODE_TERMINATE: begin
        r_pre = range_q - TermDec;
        if (offset_q >= r_pre) begin
          bin_d = 1'b1;
        end else begin
          do_renorm = 1'b1;
        end
      end
      default: begin
        o_pre  = q_item_i.window;
        r_pre  = StartRange;
        used_d = 4'd9;
      end
    endcase

    // Leading-zero count of the range gives the shift; zero range uses all nine bits.
    shift = 4'd9;
    for (int i = 0; i < 9; i++) begin
      if (r_pre[i]) begin
        shift = 4'(8 - i);
      end
    end
    range_d  = r_pre;
    offset_d = o_pre;
    if (do_renorm) begin
      used_d   = shift;
      range_d  = 9'(({9'd0, r_pre} << shift));
      offset_d = 9'(({o_pre, q_item_i.window} << shift) >> 9);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q  <= StartRange;
      offset_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        range_q  <= range_d;
        offset_q <= offset_d;
        valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      bin_q  <= bin_d;
      ctx_q  <= ctx_d;
      used_q <= used_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign bin_o           = bin_q;
  assign new_ctx_state_o = ctx_q;
  assign bits_used_o     = used_q;
endmodule

// ===== sv/cabac_binary_arithmetic_decoder.sv =====
// Top level of the binary arithmetic decoding engine.
// Usage:
// The input channel carries one word per bin request: a mode (context decision,
// bypass, terminate or start), a seven-bit context and the next nine stream bits.
// The output channel returns one word per input word: the bin, the updated
// context to write back and the number of stream bits consumed.
// A word is taken when valid is high and stall is low on its channel.
// Words pass a two-entry queue in the front end, then the back end decodes one
// word per cycle while the output is not stalled, from the range and offset registers
// into an output register. An accepted word is written into the queue first, and its
// result is registered in the output register when the back end pops it.
// The feeder must advance the stream by bits_used before it presents the window
// that depends on it, so a dependent word follows the result that it needs.
// Reset sets the range to 510 and the offset to zero and empties the queue.
// When the receiver stalls, the result holds; the queue then fills and the
// input stall rises after two more words.
module cabac_binary_arithmetic_decoder
  import cabac_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [6:0] ctx_state_i,
  input  logic [8:0] stream_bits_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       bin_o,
  output logic [6:0] new_ctx_state_o,
  output logic [3:0] bits_used_o
);
  logic  q_valid, q_pop;
  item_t q_item;

  cabac_front #(.Depth(Depth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .ctx_state_i, .stream_bits_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  cabac_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_item_i(q_item),
    .out_valid_o, .out_stall_i, .bin_o, .new_ctx_state_o, .bits_used_o
  );
endmodule
